FILE: sv/lz77_runlength_decompressor_assert.svh
// Assertion macros used by the checker file.
`ifndef LZ77_RUNLENGTH_DECOMPRESSOR_ASSERT_SVH
`define LZ77_RUNLENGTH_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define LZRL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzrl assertion failed");

// next-cycle implication
`define LZRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzrl assertion failed");

`endif

FILE: sv/lzrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzrl_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       emit;
        logic [6:0] rep;
        logic [7:0] run_next;
    } run_res_t;

    // One byte through the run decoder.
    function automatic run_res_t run_step(input logic rle_on, input logic [7:0] run_count,
                                          input logic [7:0] b);
        run_res_t r;
        r.emit     = 1'b1;
        r.rep      = 7'd1;
        r.run_next = run_count;
        if (rle_on)
        begin
            if (run_count[6:0] != 7'd0)
            begin
                if (run_count[7])
                begin
                    r.run_next = run_count - 8'd1;
                end
                else
                begin
                    r.rep      = run_count[6:0];
                    r.run_next = 8'd0;
                end
            end
            else
            begin
                // new counting byte, nothing emitted
                r.emit     = 1'b0;
                r.run_next = b;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lz77_runlength_decompressor.sv
// LZ77 + run-length stream decoder with a 4096-byte window held in one single-port-write,
// one-read synchronous RAM. After reset the window is zeroed by a clearing pass over every
// entry, during which in_ready stays low (cfg writes are taken as always). Afterwards each
// input transfer is decoded, then the last result, if any, is handed off with item_done; the
// second byte of a back-reference runs a copy of length bytes (3..18) between these steps:
// the copy moves one byte per cycle through the RAM read port, with the byte just
// written forwarded when the distance is zero. Output backpressure stalls the copy.
`timescale 1ns / 1ps
`default_nettype none

module lz77_runlength_decompressor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [6:0]      repeat_res,
    output logic            item_done
);

    localparam int AW = lzrl_pkg::WIN_AW;

    logic [7:0] window_mem [0:lzrl_pkg::WIN_DEPTH-1];

    lzrl_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]    method_reg;
    logic [AW-1:0] write_pos_reg, write_pos_next;
    logic [7:0]    flag_bits_reg, flag_bits_next;
    logic [3:0]    flag_index_reg, flag_index_next;
    logic [7:0]    ref_low_reg, ref_low_next;
    logic          ref_pending_reg, ref_pending_next;
    logic [7:0]    run_count_reg, run_count_next;
    logic          last_reg, last_next;
    logic [AW-1:0] src_reg, src_next;
    logic [4:0]    len_cnt_reg, len_cnt_next;
    logic          fwd_reg, fwd_next;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    rd_q_reg;
    logic          hold_valid_reg, hold_valid_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    logic [6:0]    hold_rep_reg, hold_rep_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [6:0]    out_rep_reg, out_rep_next;
    logic          out_done_reg, out_done_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;
    logic [7:0]    cur_byte, run_byte;
    logic          out_free, stall;
    logic [AW-1:0] ref_src, src_inc;
    logic [3:0]    flag_index_adv;
    lzrl_pkg::run_res_t rr;

    assign cur_byte = fwd_reg ? fwd_data_reg : rd_q_reg;
    assign run_byte = (state_reg == lzrl_pkg::ST_COPY) ? cur_byte : data_byte;
    assign rr       = lzrl_pkg::run_step(method_reg[0], run_count_reg, run_byte);
    assign out_free = !out_valid_reg || out_ready;
    assign stall    = rr.emit && hold_valid_reg && !out_free;
    assign ref_src  = write_pos_reg - {data_byte[3:0], ref_low_reg} - {{(AW-1){1'b0}}, 1'b1};
    assign src_inc  = src_reg + {{(AW-1){1'b0}}, 1'b1};
    assign flag_index_adv = (flag_index_reg >= 4'd8) ? 4'd0 : flag_index_reg + 4'd1;

    assign in_ready   = (state_reg == lzrl_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign repeat_res = out_rep_reg;
    assign item_done  = out_done_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        write_pos_next   = write_pos_reg;
        flag_bits_next   = flag_bits_reg;
        flag_index_next  = flag_index_reg;
        ref_low_next     = ref_low_reg;
        ref_pending_next = ref_pending_reg;
        run_count_next   = run_count_reg;
        last_next        = last_reg;
        src_next         = src_reg;
        len_cnt_next     = len_cnt_reg;
        fwd_next         = 1'b0;
        hold_valid_next  = hold_valid_reg;
        hold_byte_next   = hold_byte_reg;
        hold_rep_next    = hold_rep_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_byte_next    = out_byte_reg;
        out_rep_next     = out_rep_reg;
        out_done_next    = out_done_reg;
        mem_we           = 1'b0;
        mem_wa           = write_pos_reg;
        mem_wd           = cur_byte;
        mem_ra           = src_reg;

        case (state_reg)
            lzrl_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                mem_wd       = 8'd0;
                clr_cnt_next = clr_cnt_reg + {{(AW-1){1'b0}}, 1'b1};
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next = lzrl_pkg::ST_IDLE;
                end
            end

            lzrl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = last_byte;
                    state_next = lzrl_pkg::ST_FLUSH;
                    if (!method_reg[1])
                    begin
                        run_count_next  = rr.run_next;
                        hold_valid_next = rr.emit;
                        hold_byte_next  = data_byte;
                        hold_rep_next   = rr.rep;
                    end
                    else if (ref_pending_reg)
                    begin
                        mem_ra           = ref_src;
                        src_next         = ref_src;
                        len_cnt_next     = {1'b0, data_byte[7:4]} + 5'd3;
                        ref_pending_next = 1'b0;
                        flag_index_next  = flag_index_adv;
                        state_next       = lzrl_pkg::ST_COPY;
                    end
                    else if (flag_index_reg == 4'd0 || flag_index_reg > 4'd8)
                    begin
                        flag_bits_next  = data_byte;
                        flag_index_next = 4'd1;
                    end
                    else if (flag_bits_reg[flag_index_reg[2:0] - 3'd1])
                    begin
                        ref_low_next     = data_byte;
                        ref_pending_next = 1'b1;
                    end
                    else
                    begin
                        // literal
                        mem_we          = 1'b1;
                        mem_wd          = data_byte;
                        write_pos_next  = write_pos_reg + {{(AW-1){1'b0}}, 1'b1};
                        run_count_next  = rr.run_next;
                        hold_valid_next = rr.emit;
                        hold_byte_next  = data_byte;
                        hold_rep_next   = rr.rep;
                        flag_index_next = flag_index_adv;
                    end
                end
            end

            lzrl_pkg::ST_COPY:
            begin
                if (!stall)
                begin
                    mem_we         = 1'b1;
                    write_pos_next = write_pos_reg + {{(AW-1){1'b0}}, 1'b1};
                    run_count_next = rr.run_next;
                    if (rr.emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = hold_byte_reg;
                            out_rep_next   = hold_rep_reg;
                            out_done_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_byte_next  = cur_byte;
                        hold_rep_next   = rr.rep;
                    end
                    len_cnt_next = len_cnt_reg - 5'd1;
                    if (len_cnt_reg == 5'd1)
                    begin
                        state_next = lzrl_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        mem_ra   = src_inc;
                        src_next = src_inc;
                        // next read hits the entry written this cycle
                        fwd_next = (src_inc == write_pos_reg);
                    end
                end
                // on stall, re-read the current source byte
            end

            lzrl_pkg::ST_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = hold_byte_reg;
                        out_rep_next    = hold_rep_reg;
                        out_done_next   = 1'b1;
                        hold_valid_next = 1'b0;
                    end
                    if (last_reg)
                    begin
                        write_pos_next   = '0;
                        flag_bits_next   = 8'd0;
                        flag_index_next  = 4'd0;
                        ref_low_next     = 8'd0;
                        ref_pending_next = 1'b0;
                        run_count_next   = 8'd0;
                    end
                    state_next = lzrl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lzrl_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lzrl_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            method_reg      <= 2'd0;
            write_pos_reg   <= '0;
            flag_bits_reg   <= 8'd0;
            flag_index_reg  <= 4'd0;
            ref_low_reg     <= 8'd0;
            ref_pending_reg <= 1'b0;
            run_count_reg   <= 8'd0;
            last_reg        <= 1'b0;
            len_cnt_reg     <= 5'd0;
            fwd_reg         <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            if (cfg_we)
            begin
                method_reg <= cfg_wdata;
            end
            write_pos_reg   <= write_pos_next;
            flag_bits_reg   <= flag_bits_next;
            flag_index_reg  <= flag_index_next;
            ref_low_reg     <= ref_low_next;
            ref_pending_reg <= ref_pending_next;
            run_count_reg   <= run_count_next;
            last_reg        <= last_next;
            len_cnt_reg     <= len_cnt_next;
            fwd_reg         <= fwd_next;
            hold_valid_reg  <= hold_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        hold_byte_reg <= hold_byte_next;
        hold_rep_reg  <= hold_rep_next;
        out_byte_reg  <= out_byte_next;
        out_rep_reg   <= out_rep_next;
        out_done_reg  <= out_done_next;
        if (fwd_next)
        begin
            fwd_data_reg <= mem_wd;
        end
    end

    // window RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= window_mem[mem_ra];
    end

endmodule

`default_nettype wire

FILE: sv/lzrl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lz77_runlength_decompressor_assert.svh"

module lzrl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [6:0] repeat_res,
    input wire logic       item_done
);

    // stalled result holds
    `LZRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(repeat_res) && $stable(item_done))

    // taking an item makes in_ready drop
    `LZRL_ASSERT_NEXT(a_item_two_cycles, clk, rst_n, in_valid && in_ready, !in_ready)

    // while a non-final result of an item waits, no new item is taken
    `LZRL_ASSERT_IMPLY(a_mid_item, clk, rst_n, out_valid && !item_done, !in_ready)

    // window clearing follows reset
    `LZRL_ASSERT_IMPLY(a_clear_after_reset, clk, rst_n, $past(!rst_n), !in_ready)

endmodule

bind lz77_runlength_decompressor lzrl_checker u_lzrl_checker (.*);

`default_nettype wire
